/* hw/rtl/bitmap_id_allocator_macros.svh */
// Assertion macros shared by the id allocator checker.
`ifndef BITMAP_ID_ALLOCATOR_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_MACROS_SVH

// Same-cycle implication under the checker clock and reset.
`define BIA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under the checker clock and reset.
`define BIA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/bia_pkg.sv */
// Package: sizes, codes and helpers of the bitmap id allocator.
`default_nettype none
package bia_pkg;

   localparam int NUM_IDS = 256;
   localparam int ID_BASE = 256;

   // request and response field widths
   localparam int MODE_W = 1;
   localparam int PRIO_W = 3;
   localparam int ID_W   = 9;
   localparam int STAT_W = 2;

   localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;
   localparam logic [PRIO_W-1:0] PRIO_MIN   = 3'd1;
   localparam logic [PRIO_W-1:0] PRIO_MAX   = 3'd4;

   // bitmap organization: 32-bit words
   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int NUM_WORDS  = (NUM_IDS + WORD_W - 1) / WORD_W;
   localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int CUR_W      = $clog2(NUM_IDS + 1);
   localparam int ID_SUM_RAW = $clog2(ID_BASE + NUM_IDS + 1);
   localparam int ID_SUM_W   = (ID_SUM_RAW > ID_W) ? ID_SUM_RAW : ID_W + 1;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_BAD_PRIO = 2'd1,
      ST_FULL     = 2'd2,
      ST_BAD_ID   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ,
      S_MODIFY,
      S_RESULT
   } state_type;

   // command to the word unit
   typedef struct packed {
      logic search;   // pick the lowest free bit instead of the target bit
      logic set;      // set the chosen bit, else clear it
   } op_type;

   // bits past the end of the pool read as used
   function automatic logic [WORD_W-1:0] pad_mask(input logic [WORD_IDX_W-1:0] word_idx);
      logic [WORD_W-1:0] mask;
      mask = '0;
      for (int i = 0; i < WORD_W; i++) begin
         mask[i] = ((int'(word_idx) * WORD_W + i) >= NUM_IDS);
      end
      return mask;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/bia_ifs.sv */
// Request and response channel interfaces of the id allocator.
`default_nettype none
interface bia_req_if;
   logic                        valid;
   logic                        ready;
   logic [bia_pkg::MODE_W-1:0]  mode;
   logic [bia_pkg::PRIO_W-1:0]  priority_req;
   logic [bia_pkg::ID_W-1:0]    free_id;

   modport source (output valid, mode, priority_req, free_id, input ready);
   modport sink   (input valid, mode, priority_req, free_id, output ready);
endinterface

interface bia_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bia_pkg::STAT_W-1:0]  status;
   logic [bia_pkg::ID_W-1:0]    granted_id;
   logic [bia_pkg::PRIO_W-1:0]  granted_priority;

   modport source (output valid, status, granted_id, granted_priority, input ready);
   modport sink   (input valid, status, granted_id, granted_priority, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bia_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bia_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/bia_word_unit.sv */
// Shared word unit: find the lowest free bit or take the target bit, then set or clear that bit.
`default_nettype none
module bia_word_unit (
   input  wire logic [bia_pkg::WORD_W-1:0] word,
   input  wire bia_pkg::op_type            op,
   input  wire logic [bia_pkg::BIT_W-1:0]  target_bit,
   output logic      [bia_pkg::WORD_W-1:0] word_out,
   output logic                            hit,
   output logic      [bia_pkg::BIT_W-1:0]  bit_idx
);

   logic [bia_pkg::WORD_W-1:0] free_bits;
   logic [bia_pkg::WORD_W-1:0] lowest;
   logic [bia_pkg::BIT_W-1:0]  found_idx;
   logic [bia_pkg::WORD_W-1:0] bit_mask;

   // isolate the lowest free bit, then encode it
   always_comb begin
      free_bits = ~word;
      lowest    = free_bits & (bia_pkg::WORD_W'(0) - free_bits);
      found_idx = '0;
      for (int i = 0; i < bia_pkg::WORD_W; i++) begin
         if (lowest[i]) begin
            found_idx = found_idx | bia_pkg::BIT_W'(i);
         end
      end
   end

   always_comb begin
      hit      = op.search ? (|free_bits) : 1'b1;
      bit_idx  = op.search ? found_idx : target_bit;
      bit_mask = bia_pkg::WORD_W'(1) << bit_idx;
      word_out = op.set ? (word | bit_mask) : (word & ~bit_mask);
   end

endmodule
`default_nettype wire

/* hw/rtl/bitmap_id_allocator.sv */
// Top level of the bitmap id allocator: sequencer, bitmap RAM and word unit.
//
//   channel | dir | fields                                  | handshake
//   req_if  | in  | mode, priority_req, free_id             | valid/ready
//   rsp_if  | out | status, granted_id, granted_priority    | valid/ready
//
// One request is in work at a time; req_if.ready is high only when idle.
// From accept to response valid: a bad priority or bad id goes CHECK, RESULT;
// a bump grant or a free goes CHECK, READ, MODIFY, RESULT; a bitmap scan repeats
// READ and MODIFY for at most NUM_WORDS words: one RAM read and one word unit pass per word.
// The response register holds a stalled result; only the load into it waits.
// Synchronous reset clears the row valid bits, bump cursor and control state.
`default_nettype none
module bitmap_id_allocator (
   input  wire logic  clock,
   input  wire logic  reset,
   bia_req_if.sink    req_if,
   bia_rsp_if.source  rsp_if
);

   localparam int WIW = bia_pkg::WORD_IDX_W;

   bia_pkg::state_type state_ff, state_in;

   // latched request
   logic [bia_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [bia_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic [bia_pkg::ID_W-1:0]   fid_ff, fid_in;

   // work registers
   logic [bia_pkg::CUR_W-1:0]  cursor_ff, cursor_in;
   logic [WIW-1:0]             word_addr_ff, word_addr_in;
   logic [bia_pkg::BIT_W-1:0]  bit_ff, bit_in;
   bia_pkg::op_type            op_ff, op_in;
   logic                       bump_ff, bump_in;
   logic [bia_pkg::NUM_WORDS-1:0] row_valid_ff, row_valid_in;

   // staged result
   bia_pkg::status_type        res_status_ff, res_status_in;
   logic [bia_pkg::ID_W-1:0]   res_id_ff, res_id_in;
   logic [bia_pkg::PRIO_W-1:0] res_prio_ff, res_prio_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bia_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [bia_pkg::ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [bia_pkg::PRIO_W-1:0] rsp_prio_ff, rsp_prio_in;

   // RAM and word unit
   logic                         ram_wr_en, ram_rd_en;
   logic [bia_pkg::WORD_W-1:0]   ram_rd_data, ram_wr_data;
   logic [bia_pkg::WORD_W-1:0]   word_eff;
   logic                         unit_hit;
   logic [bia_pkg::BIT_W-1:0]    unit_bit;

   // decode helpers
   logic                         req_fire, rsp_fire, out_free;
   logic [bia_pkg::ID_SUM_W-1:0] fid_ext, fid_off, grant_sum;
   logic                         id_in_range, prio_ok, bump_live, last_word;

   always_comb begin
      req_fire    = req_if.valid && req_if.ready;
      rsp_fire    = rsp_valid_ff && rsp_if.ready;
      out_free    = !rsp_valid_ff || rsp_if.ready;
      fid_ext     = bia_pkg::ID_SUM_W'(fid_ff);
      fid_off     = fid_ext - bia_pkg::ID_SUM_W'(bia_pkg::ID_BASE);
      id_in_range = (fid_ext >= bia_pkg::ID_SUM_W'(bia_pkg::ID_BASE)) &&
                    (fid_ext < bia_pkg::ID_SUM_W'(bia_pkg::ID_BASE + bia_pkg::NUM_IDS));
      prio_ok     = (prio_ff >= bia_pkg::PRIO_MIN) && (prio_ff <= bia_pkg::PRIO_MAX);
      bump_live   = cursor_ff < bia_pkg::CUR_W'(bia_pkg::NUM_IDS);
      last_word   = word_addr_ff == WIW'(bia_pkg::NUM_WORDS - 1);
      // a row never written reads as all free; bits past the pool read as used
      word_eff    = (row_valid_ff[word_addr_ff] ? ram_rd_data : '0) |
                    bia_pkg::pad_mask(word_addr_ff);
      grant_sum   = bia_pkg::ID_SUM_W'(bia_pkg::ID_BASE) +
                    bia_pkg::ID_SUM_W'({word_addr_ff, unit_bit});
   end

   bia_ram #(
      .WIDTH (bia_pkg::WORD_W),
      .DEPTH (bia_pkg::NUM_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (word_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (word_addr_ff),
      .rd_data (ram_rd_data)
   );

   bia_word_unit u_word_unit (
      .word       (word_eff),
      .op         (op_ff),
      .target_bit (bit_ff),
      .word_out   (ram_wr_data),
      .hit        (unit_hit),
      .bit_idx    (unit_bit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bia_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = bia_pkg::S_CHECK;
            end
         end
         bia_pkg::S_CHECK: begin
            if (mode_ff == bia_pkg::MODE_FREE) begin
               state_in = id_in_range ? bia_pkg::S_READ : bia_pkg::S_RESULT;
            end else begin
               state_in = prio_ok ? bia_pkg::S_READ : bia_pkg::S_RESULT;
            end
         end
         bia_pkg::S_READ: begin
            state_in = bia_pkg::S_MODIFY;
         end
         bia_pkg::S_MODIFY: begin
            // keep scanning while the word is full and words remain
            if (!unit_hit && !last_word) begin
               state_in = bia_pkg::S_READ;
            end else begin
               state_in = bia_pkg::S_RESULT;
            end
         end
         bia_pkg::S_RESULT: begin
            if (out_free) begin
               state_in = bia_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bia_pkg::S_IDLE;
         end
      endcase
   end

   // outputs and data path registers
   always_comb begin
      req_if.ready  = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      mode_in       = mode_ff;
      prio_in       = prio_ff;
      fid_in        = fid_ff;
      cursor_in     = cursor_ff;
      word_addr_in  = word_addr_ff;
      bit_in        = bit_ff;
      op_in         = op_ff;
      bump_in       = bump_ff;
      row_valid_in  = row_valid_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_prio_in   = res_prio_ff;
      rsp_valid_in  = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;

      case (state_ff)
         bia_pkg::S_IDLE: begin
            req_if.ready = 1'b1;
            if (req_fire) begin
               mode_in = req_if.mode;
               prio_in = req_if.priority_req;
               fid_in  = req_if.free_id;
            end
         end
         bia_pkg::S_CHECK: begin
            res_id_in   = '0;
            res_prio_in = '0;
            bump_in     = 1'b0;
            if (mode_ff == bia_pkg::MODE_FREE) begin
               res_status_in = bia_pkg::ST_BAD_ID;
               word_addr_in  = WIW'(fid_off >> bia_pkg::BIT_W);
               bit_in        = fid_off[bia_pkg::BIT_W-1:0];
               op_in         = '{search: 1'b0, set: 1'b0};
            end else if (!prio_ok) begin
               res_status_in = bia_pkg::ST_BAD_PRIO;
            end else if (bump_live) begin
               // bump phase: grant the cursor slot
               word_addr_in = WIW'(cursor_ff >> bia_pkg::BIT_W);
               bit_in       = bia_pkg::BIT_W'(cursor_ff);
               op_in        = '{search: 1'b0, set: 1'b1};
               bump_in      = 1'b1;
            end else begin
               // scan phase: start at word zero
               word_addr_in = '0;
               op_in        = '{search: 1'b1, set: 1'b1};
            end
         end
         bia_pkg::S_READ: begin
            ram_rd_en = 1'b1;
         end
         bia_pkg::S_MODIFY: begin
            if (unit_hit) begin
               ram_wr_en                  = 1'b1;
               row_valid_in[word_addr_ff] = 1'b1;
               res_status_in              = bia_pkg::ST_OK;
               if (bump_ff) begin
                  cursor_in = cursor_ff + bia_pkg::CUR_W'(1);
               end
               if (op_ff.set) begin
                  res_id_in   = grant_sum[bia_pkg::ID_W-1:0];
                  res_prio_in = prio_ff;
               end
            end else if (last_word) begin
               res_status_in = bia_pkg::ST_FULL;
            end else begin
               word_addr_in = word_addr_ff + WIW'(1);
            end
         end
         bia_pkg::S_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_prio_in   = res_prio_ff;
            end
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bia_pkg::S_IDLE;
         cursor_ff    <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      prio_ff       <= prio_in;
      fid_ff        <= fid_in;
      word_addr_ff  <= word_addr_in;
      bit_ff        <= bit_in;
      op_ff         <= op_in;
      bump_ff       <= bump_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_prio_ff   <= res_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_prio_ff   <= rsp_prio_in;
   end

   always_comb begin
      rsp_if.valid            = rsp_valid_ff;
      rsp_if.status           = rsp_status_ff;
      rsp_if.granted_id       = rsp_id_ff;
      rsp_if.granted_priority = rsp_prio_ff;
   end

endmodule
`default_nettype wire

/* hw/rtl/bia_checker.sv */
// Port checker for the id allocator and its bind.
`default_nettype none
`include "bitmap_id_allocator_macros.svh"
module bia_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [bia_pkg::STAT_W-1:0]  rsp_status,
   input wire logic [bia_pkg::ID_W-1:0]    rsp_granted_id,
   input wire logic [bia_pkg::PRIO_W-1:0]  rsp_granted_priority
);

   // stalled response holds
   `BIA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_granted_id) && $stable(rsp_granted_priority), "stalled response changed")

   // one request in work at a time
   `BIA_ASSERT_NXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // refused requests grant nothing
   `BIA_ASSERT_IMP(a_refuse_empty, clock, reset, rsp_valid && (rsp_status != bia_pkg::ST_OK), (rsp_granted_id == '0) && (rsp_granted_priority == '0), "refusal carries a grant")

   // a granted priority is a legal one
   `BIA_ASSERT_IMP(a_prio_range, clock, reset, rsp_valid && (rsp_granted_priority != '0), (rsp_status == bia_pkg::ST_OK) && (rsp_granted_priority <= bia_pkg::PRIO_MAX), "granted priority out of range")

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_if.valid),
   .req_ready            (req_if.ready),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_status           (rsp_if.status),
   .rsp_granted_id       (rsp_if.granted_id),
   .rsp_granted_priority (rsp_if.granted_priority)
);
`default_nettype wire
